@@ sv/skle_pkg.sv @@
package skle_pkg;

	// field widths fixed by the transaction format
	localparam int KEY_W   = 32;
	localparam int TYPE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// request codes
	localparam logic [TYPE_W-1:0] OP_SEARCH = 2'd0;
	localparam logic [TYPE_W-1:0] OP_INSERT = 2'd1;
	localparam logic [TYPE_W-1:0] OP_DELETE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0]       req_type;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// per-cell update commands
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

@@ sv/skle_cell.sv @@
module skle_cell (
	input  logic                                clk,
	input  skle_pkg::cell_ctl_t                 ctl,
	input  logic signed [skle_pkg::KEY_W-1:0]   key,
	input  logic                                occ,
	input  logic                                left_g,
	input  logic signed [skle_pkg::KEY_W-1:0]   left_key,
	input  logic signed [skle_pkg::KEY_W-1:0]   right_key,
	output logic signed [skle_pkg::KEY_W-1:0]   key_out,
	output logic                                g,
	output logic                                eq
);

	logic signed [skle_pkg::KEY_W-1:0] key_q;

	// empty cells act as +infinity so g forms a thermometer along the row
	assign g       = !occ || (key_q >= key);
	assign eq      = occ && (key_q == key);
	assign key_out = key_q;

	// insert shifts up from the left neighbour, delete pulls from the right one
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_g) begin
				key_q <= left_key;
			end else if (g) begin
				key_q <= key;
			end
		end else if (ctl.del) begin
			if (g) begin
				key_q <= right_key;
			end
		end
	end

endmodule

@@ sv/sorted_key_list_engine_unit.sv @@
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | skle_pkg::req_t  (req_type, key)
// rsp     | out       | rsp_valid / rsp_stall  | skle_pkg::rsp_t  (status, entry_count)
//
// One request per clock: every cell compares the key at once, an insert or delete
// shifts the row of cells by one place in the same cycle, the result shows in the next.
// A request is taken unless a result is waiting and rsp_stall is high.
// Reset empties the list at once; no clearing pass, stored keys are not reset.
module sorted_key_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  skle_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output skle_pkg::rsp_t  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [skle_pkg::KEY_W-1:0] keys [CAPACITY];
	logic [CAPACITY-1:0]               g_vec;
	logic [CAPACITY-1:0]               eq_vec;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_nxt;
	logic                              acc;
	logic                              hit;
	logic                              full;
	skle_pkg::cell_ctl_t               ctl;
	logic [skle_pkg::STAT_W-1:0]       status;
	logic                              rsp_valid_q;
	skle_pkg::rsp_t                    rsp_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;
	assign hit       = |eq_vec;
	assign full      = (count_q == CW'(CAPACITY));

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                              occ;
		logic                              lg;
		logic signed [skle_pkg::KEY_W-1:0] lk;
		logic signed [skle_pkg::KEY_W-1:0] rk;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign lg = 1'b0;
			assign lk = req.key;
		end else begin : g_mid
			assign lg = g_vec[i-1];
			assign lk = keys[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rk = keys[i];
		end else begin : g_inner
			assign rk = keys[i+1];
		end

		skle_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (req.key),
			.occ       (occ),
			.left_g    (lg),
			.left_key  (lk),
			.right_key (rk),
			.key_out   (keys[i]),
			.g         (g_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	// decode request into status, cell commands and the new count
	always_comb begin
		ctl       = '0;
		status    = skle_pkg::ST_NOT_FOUND;
		count_nxt = count_q;
		case (req.req_type)
			skle_pkg::OP_SEARCH: begin
				status = hit ? skle_pkg::ST_OK : skle_pkg::ST_NOT_FOUND;
			end
			skle_pkg::OP_INSERT: begin
				if (full) begin
					status = skle_pkg::ST_FULL;
				end else begin
					status    = skle_pkg::ST_OK;
					ctl.ins   = acc;
					count_nxt = count_q + CW'(1);
				end
			end
			skle_pkg::OP_DELETE: begin
				if (hit) begin
					status    = skle_pkg::ST_OK;
					ctl.del   = acc;
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				status = skle_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	// count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q.status      <= status;
			rsp_q.entry_count <= skle_pkg::COUNT_W'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/skle_checker.sv @@
module skle_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input skle_pkg::req_t  req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input skle_pkg::rsp_t  rsp
);

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// no new request while the result register is blocked
	a_req_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while result waits");

	// every accepted transaction gives a result next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted transaction without result");

	// full status only answers an insert
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.req_type != skle_pkg::OP_INSERT)
		|=> rsp.status != skle_pkg::ST_FULL)
		else $error("full status on a non-insert");

endmodule

bind sorted_key_list_engine_unit skle_checker u_skle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
